### rtl/core/smt_pkg.sv
// shared types and constants for the sparse matrix transpose block
`default_nettype none

package smt_pkg;

  // fixed field widths of the term words
  localparam int TERM_IDX_W  = 4;
  localparam int OUT_VALUE_W = 32;

  // default sizing
  localparam int DEF_MAX_TERMS  = 64;
  localparam int DEF_MAX_DIM    = 16;
  localparam int DEF_VALUE_BITS = 32;

  // one classified word on its way from front to back
  typedef struct packed {
    logic [TERM_IDX_W-1:0]  row;
    logic [TERM_IDX_W-1:0]  col;
    logic [OUT_VALUE_W-1:0] value;
    logic                   last;
    logic                   keep;
  } qitem_t;

endpackage

`default_nettype wire

### rtl/core/sparse_matrix_transpose.sv
// top level of the sparse matrix transpose block
//
// usage
//   in_ channel: one nonzero term (row, col, value) per word, in_last_term on
//   the final term of a matrix. out_ channel: the transposed terms, ordered by
//   original column and in arrival order within a column, out_last on the final
//   one and out_dropped set on every word of a matrix that lost terms (column
//   out of range or term store full). a matrix with no stored term gives one
//   all-zero marker word with out_last and out_dropped set
//   both channels: word moves on a clock edge with valid high and stall low
// timing
//   terms pass a two word queue and are written one per cycle into the term
//   store while the back end is loading; the final term starts a prefix pass
//   over the columns (min(MAX_DIM,16)), a scatter pass through the term store
//   read port, then emit, each result read through the sorted store read port
//   and then moved into the output register
//   the queue takes up to two words of the next matrix while one is sorted
// reset and stall
//   synchronous active-low reset empties the queue, clears counts, flags and
//   out_valid; no clearing pass is needed. a stalled out word holds, and the
//   back end waits on it while the front keeps filling its queue
`default_nettype none

module sparse_matrix_transpose #(
  parameter int MAX_TERMS  = smt_pkg::DEF_MAX_TERMS,
  parameter int MAX_DIM    = smt_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = smt_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [smt_pkg::TERM_IDX_W-1:0]         in_term_row,
  input  wire logic [smt_pkg::TERM_IDX_W-1:0]         in_term_col,
  input  wire logic signed [smt_pkg::OUT_VALUE_W-1:0] in_term_value,
  input  wire logic                                   in_last_term,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [smt_pkg::TERM_IDX_W-1:0]              out_row,
  output logic [smt_pkg::TERM_IDX_W-1:0]              out_col,
  output logic signed [smt_pkg::OUT_VALUE_W-1:0]      out_value,
  output logic                                        out_last,
  output logic                                        out_dropped
);

  // classified words between front and back
  logic            q_valid;
  logic            q_pop;
  smt_pkg::qitem_t q_item;

  // front: narrows value, checks column range, queues the word
  smt_front #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_term_row   (in_term_row),
    .in_term_col   (in_term_col),
    .in_term_value (in_term_value),
    .in_last_term  (in_last_term),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back: store, count, prefix, scatter, emit through the output register
  smt_back #(
    .MAX_TERMS  (MAX_TERMS),
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .out_last    (out_last),
    .out_dropped (out_dropped)
  );

endmodule

`default_nettype wire

### rtl/core/smt_front.sv
// input side: value narrowing, column range check and a two entry queue
`default_nettype none

module smt_front #(
  parameter int MAX_DIM    = smt_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = smt_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [smt_pkg::TERM_IDX_W-1:0]      in_term_row,
  input  wire logic [smt_pkg::TERM_IDX_W-1:0]      in_term_col,
  input  wire logic signed [smt_pkg::OUT_VALUE_W-1:0] in_term_value,
  input  wire logic                                in_last_term,
  output logic                                     q_valid,
  output smt_pkg::qitem_t                          q_item,
  input  wire logic                                q_pop
);

  localparam int SW = (VALUE_BITS < smt_pkg::OUT_VALUE_W) ? VALUE_BITS
                                                           : smt_pkg::OUT_VALUE_W;
  localparam logic [8:0] DIM_LIM = 9'(MAX_DIM);

  smt_pkg::qitem_t item_in;
  smt_pkg::qitem_t q_mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      fill_r;
  logic [1:0]      fill_nxt;
  logic            push;
  logic            pop;

  always_comb begin
    item_in.row   = in_term_row;
    item_in.col   = in_term_col;
    // keep the low value bits and sign-extend them to the word width
    item_in.value = smt_pkg::OUT_VALUE_W'($signed(in_term_value[SW-1:0]));
    item_in.last  = in_last_term;
    item_in.keep  = (9'(in_term_col) < DIM_LIM);
  end

  assign in_stall = (fill_r == 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign fill_nxt = fill_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= item_in;
  end

endmodule

`default_nettype wire

### rtl/core/smt_back.sv
// work side: term load, column prefix, stable scatter and result emit
`default_nettype none

module smt_back #(
  parameter int MAX_TERMS  = smt_pkg::DEF_MAX_TERMS,
  parameter int MAX_DIM    = smt_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = smt_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   q_valid,
  input  wire smt_pkg::qitem_t                        q_item,
  output logic                                        q_pop,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [smt_pkg::TERM_IDX_W-1:0]              out_row,
  output logic [smt_pkg::TERM_IDX_W-1:0]              out_col,
  output logic signed [smt_pkg::OUT_VALUE_W-1:0]      out_value,
  output logic                                        out_last,
  output logic                                        out_dropped
);

  localparam int IDX_SPAN = 2 ** smt_pkg::TERM_IDX_W;
  localparam int NCOL  = (MAX_DIM < IDX_SPAN) ? MAX_DIM : IDX_SPAN;
  localparam int CIW   = $clog2(NCOL);
  localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW    = $clog2(MAX_TERMS + 1);
  localparam int SW    = (VALUE_BITS < smt_pkg::OUT_VALUE_W) ? VALUE_BITS
                                                              : smt_pkg::OUT_VALUE_W;
  localparam int RW    = smt_pkg::TERM_IDX_W;
  localparam int ENT_W = RW + CIW + SW;

  localparam logic [CW-1:0]  HELD_MAX = CW'(MAX_TERMS);
  localparam logic [CIW-1:0] COL_LAST = CIW'(NCOL - 1);

  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_PREFIX   = 3'd1;
  localparam logic [2:0] ST_SCAT     = 3'd2;
  localparam logic [2:0] ST_EMIT_RD  = 3'd3;
  localparam logic [2:0] ST_EMIT_OUT = 3'd4;
  localparam logic [2:0] ST_MARK     = 3'd5;

  // term store entry {row, col, value}, sorted entry {col, row, value}
  logic [ENT_W-1:0] term_mem [MAX_TERMS];
  logic [ENT_W-1:0] sort_mem [MAX_TERMS];
  logic [ENT_W-1:0] term_rd_r;
  logic [ENT_W-1:0] sort_rd_r;

  logic [CW-1:0]  cnt_r   [NCOL];
  logic [CW-1:0]  start_r [NCOL];

  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  held_r, held_nxt;
  logic           ovf_r, ovf_nxt;
  logic [CIW-1:0] pi_r, pi_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]  sc_idx_r, sc_idx_nxt;
  logic           sc_vld_r, sc_vld_nxt;
  logic [CW-1:0]  em_idx_r, em_idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [RW-1:0]  out_row_r, out_row_nxt;
  logic [RW-1:0]  out_col_r, out_col_nxt;
  logic [SW-1:0]  out_val_r, out_val_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_drop_r, out_drop_nxt;

  logic           keep_now;
  logic           term_wr_en;
  logic           term_rd_en;
  logic           sort_wr_en;
  logic           sort_rd_en;
  logic           cnt_inc;
  logic           cnt_clr;
  logic           start_set;
  logic           start_inc;
  logic           out_free;
  logic [CW-1:0]  em_next;
  logic [CIW-1:0] q_col;
  logic [RW-1:0]  t_row;
  logic [CIW-1:0] t_col;
  logic [SW-1:0]  t_val;
  logic [CIW-1:0] s_row;
  logic [RW-1:0]  s_col;
  logic [SW-1:0]  s_val;
  logic [CW-1:0]  t_pos;

  assign q_col = q_item.col[CIW-1:0];
  assign t_row = term_rd_r[ENT_W-1 -: RW];
  assign t_col = term_rd_r[SW +: CIW];
  assign t_val = term_rd_r[SW-1:0];
  assign s_row = sort_rd_r[ENT_W-1 -: CIW];
  assign s_col = sort_rd_r[SW +: RW];
  assign s_val = sort_rd_r[SW-1:0];
  assign t_pos = start_r[t_col];

  assign out_free = !out_valid_r || !out_stall;
  assign em_next  = em_idx_r + CW'(1);
  assign keep_now = q_item.keep && (held_r != HELD_MAX);

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    ovf_nxt       = ovf_r;
    pi_nxt        = pi_r;
    pos_nxt       = pos_r;
    sc_idx_nxt    = sc_idx_r;
    sc_vld_nxt    = sc_vld_r;
    em_idx_nxt    = em_idx_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    term_wr_en    = 1'b0;
    term_rd_en    = 1'b0;
    sort_wr_en    = 1'b0;
    sort_rd_en    = 1'b0;
    cnt_inc       = 1'b0;
    cnt_clr       = 1'b0;
    start_set     = 1'b0;
    start_inc     = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        q_pop = 1'b1;
        if (q_valid) begin
          if (keep_now) begin
            term_wr_en = 1'b1;
            cnt_inc    = 1'b1;
            held_nxt   = held_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_item.last) begin
            pi_nxt  = '0;
            pos_nxt = '0;
            if (keep_now || held_r != '0) state_nxt = ST_PREFIX;
            else                          state_nxt = ST_MARK;
          end
        end
      end
      ST_PREFIX: begin
        start_set = 1'b1;
        cnt_clr   = 1'b1;
        pos_nxt   = pos_r + cnt_r[pi_r];
        pi_nxt    = pi_r + CIW'(1);
        if (pi_r == COL_LAST) begin
          sc_idx_nxt = '0;
          sc_vld_nxt = 1'b0;
          state_nxt  = ST_SCAT;
        end
      end
      ST_SCAT: begin
        if (sc_idx_r != held_r) begin
          term_rd_en = 1'b1;
          sc_idx_nxt = sc_idx_r + CW'(1);
          sc_vld_nxt = 1'b1;
        end else begin
          sc_vld_nxt = 1'b0;
        end
        if (sc_vld_r) begin
          sort_wr_en = 1'b1;
          start_inc  = 1'b1;
          if (sc_idx_r == held_r) begin
            em_idx_nxt = '0;
            state_nxt  = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        sort_rd_en = 1'b1;
        state_nxt  = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = RW'(s_row);
          out_col_nxt   = s_col;
          out_val_nxt   = s_val;
          out_last_nxt  = (em_next == held_r);
          out_drop_nxt  = ovf_r;
          em_idx_nxt    = em_next;
          if (em_next == held_r) begin
            held_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = '0;
          out_col_nxt   = '0;
          out_val_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_drop_nxt  = 1'b1;
          held_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      held_r      <= '0;
      ovf_r       <= 1'b0;
      sc_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      ovf_r       <= ovf_nxt;
      sc_vld_r    <= sc_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pi_r       <= pi_nxt;
    pos_r      <= pos_nxt;
    sc_idx_r   <= sc_idx_nxt;
    em_idx_r   <= em_idx_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  // column counts start at zero and are cleared by the prefix pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOL; i++) cnt_r[i] <= '0;
    end else if (cnt_inc) begin
      cnt_r[q_col] <= cnt_r[q_col] + CW'(1);
    end else if (cnt_clr) begin
      cnt_r[pi_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_set)      start_r[pi_r]  <= pos_r;
    else if (start_inc) start_r[t_col] <= t_pos + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (term_wr_en) begin
      term_mem[held_r[AW-1:0]] <= {q_item.row, q_col, q_item.value[SW-1:0]};
    end
    if (term_rd_en) term_rd_r <= term_mem[sc_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sort_wr_en) sort_mem[t_pos[AW-1:0]] <= {t_col, t_row, t_val};
    if (sort_rd_en) sort_rd_r <= sort_mem[em_idx_r[AW-1:0]];
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_value   = smt_pkg::OUT_VALUE_W'($signed(out_val_r));
  assign out_last    = out_last_r;
  assign out_dropped = out_drop_r;

endmodule

`default_nettype wire

### rtl/core/smt_checker.sv
// port checker for the sparse matrix transpose block and its bind
`default_nettype none

module smt_checker (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   out_valid,
  input wire logic                                   out_stall,
  input wire logic [smt_pkg::TERM_IDX_W-1:0]         out_row,
  input wire logic [smt_pkg::TERM_IDX_W-1:0]         out_col,
  input wire logic signed [smt_pkg::OUT_VALUE_W-1:0] out_value,
  input wire logic                                   out_last,
  input wire logic                                   out_dropped
);

  logic                          mid_r;
  logic [smt_pkg::TERM_IDX_W-1:0] prev_row_r;
  logic                          prev_drop_r;

  // track the last taken word inside a matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      mid_r <= !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      prev_row_r  <= out_row;
      prev_drop_r <= out_dropped;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_value) && $stable(out_last) && $stable(out_dropped))
    else $error("stalled out word changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> out_row >= prev_row_r)
    else $error("transposed rows out of order within a matrix");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> out_dropped == prev_drop_r)
    else $error("dropped flag changed within a matrix");

endmodule

bind sparse_matrix_transpose smt_checker u_smt_checker (.*);

`default_nettype wire
